// ----- sv/ssd_pkg.sv -----
// Shared constants and types for the SRRIP set-dueling replacement block.
package ssd_pkg;

  // Cache geometry (sets and ways are powers of two)
  localparam int NUM_SETS      = 2048;
  localparam int NUM_WAYS      = 16;
  localparam int LEADER_SETS   = 32;
  localparam int SELECTOR_BITS = 10;

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int WAY_W   = $clog2(NUM_WAYS);
  localparam int RRPV_W  = 2;
  localparam int ROW_W   = NUM_WAYS * RRPV_W;
  localparam int ADDR_W  = 48;
  localparam int DELTA_W = ADDR_W + 1;
  localparam int CONF_W  = 2;

  // Fixed payload widths of the channels
  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;

  // Re-reference values
  localparam logic [RRPV_W-1:0] RRPV_NEAR    = 2'd0;
  localparam logic [RRPV_W-1:0] RRPV_START   = 2'd2;
  localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;

  localparam logic [CONF_W-1:0] CONF_MAX    = 2'd3;
  localparam logic [CONF_W-1:0] CONF_STREAM = 2'd2;

  localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = {SELECTOR_BITS{1'b1}};

  // Operation codes
  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Per-set stride detector entry
  typedef struct packed {
    logic [ADDR_W-1:0]         prior_address;
    logic signed [DELTA_W-1:0] prior_delta;
    logic [CONF_W-1:0]         confidence;
  } det_t;

  localparam int DET_W = $bits(det_t);

endpackage

// ----- sv/ssd_ifs.sv -----
// Request and response channel interfaces.
interface ssd_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [ssd_pkg::SET_IN_W-1:0]  set_index;
  logic [ssd_pkg::WAY_IN_W-1:0]  way_index;
  logic [ssd_pkg::ADDR_W-1:0]    address;
  logic                          was_hit;

  modport source (output valid, operation, set_index, way_index, address, was_hit,
                  input ready);
  modport sink (input valid, operation, set_index, way_index, address, was_hit,
                output ready);
endinterface

interface ssd_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] victim_way;
  logic       inserted_distant;
  logic       policy_srrip;

  modport source (output valid, victim_way, inserted_distant, policy_srrip,
                  input ready);
  modport sink (input valid, victim_way, inserted_distant, policy_srrip,
                output ready);
endinterface

// ----- sv/ssd_victim.sv -----
// Victim selection and aging over one set's re-reference row.
module ssd_victim (
  input  logic [ssd_pkg::ROW_W-1:0] row,
  output logic [ssd_pkg::WAY_W-1:0] pick,
  output logic [ssd_pkg::ROW_W-1:0] aged_row
);

  logic [ssd_pkg::NUM_WAYS-1:0] eq3, eq2, eq1, match;
  logic [ssd_pkg::RRPV_W-1:0]   top;
  logic [ssd_pkg::RRPV_W-1:0]   age;

  // Per-way value decode
  always_comb begin
    for (int w = 0; w < ssd_pkg::NUM_WAYS; w++) begin
      eq3[w] = row[w*ssd_pkg::RRPV_W +: ssd_pkg::RRPV_W] == 2'd3;
      eq2[w] = row[w*ssd_pkg::RRPV_W +: ssd_pkg::RRPV_W] == 2'd2;
      eq1[w] = row[w*ssd_pkg::RRPV_W +: ssd_pkg::RRPV_W] == 2'd1;
    end
  end

  // Largest value present, and the ways holding it
  always_comb begin
    if (|eq3) begin
      top   = 2'd3;
      match = eq3;
    end else if (|eq2) begin
      top   = 2'd2;
      match = eq2;
    end else if (|eq1) begin
      top   = 2'd1;
      match = eq1;
    end else begin
      top   = 2'd0;
      match = '1;
    end
  end

  // Lowest matching way
  always_comb begin
    pick = '0;
    for (int w = ssd_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) pick = ssd_pkg::WAY_W'(w);
    end
  end

  // Age every way so the largest lands on distant
  assign age = ssd_pkg::RRPV_DISTANT - top;

  always_comb begin
    for (int w = 0; w < ssd_pkg::NUM_WAYS; w++) begin
      aged_row[w*ssd_pkg::RRPV_W +: ssd_pkg::RRPV_W] =
        row[w*ssd_pkg::RRPV_W +: ssd_pkg::RRPV_W] + age;
    end
  end

endmodule

// ----- sv/srrip_stream_duel_replacement.sv -----
// Top level: SRRIP replacement with stride detection and set dueling.
//
// Channels: req carries one request per transfer. operation 0 asks for a
// victim way of set_index; operation 1 records an access (way_index,
// address, was_hit). rsp returns exactly one result per request: the victim
// way, or for an update the chosen policy and whether the line went in at
// distant.
// Operation: one request at a time. The idle state takes a request and
// reads the set's row and stride entry from two single-port memories; the
// execute state computes, writes the row back (and the stride entry for an
// update) and loads the response register. A new request is taken only
// once the block is back in the idle state.
// Reset: rst clears control and the selector, then a clearing pass writes
// every set of both memories, one set per cycle; req.ready stays low until
// it ends.
// Stalls: the response register holds its result while rsp.ready is low; a
// further request may be taken meanwhile and waits in its compute cycle
// until the register frees.
module srrip_stream_duel_replacement (
  input logic      clk,
  input logic      rst,
  ssd_req_if.sink  req,
  ssd_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // Memories
  logic [ssd_pkg::ROW_W-1:0] reref_mem [ssd_pkg::NUM_SETS];
  ssd_pkg::det_t             det_mem   [ssd_pkg::NUM_SETS];

  logic [ssd_pkg::ROW_W-1:0] rd_row;
  ssd_pkg::det_t             rd_det;

  // Latched request
  logic                            op_q;
  logic [ssd_pkg::SET_W-1:0]       set_q;
  logic [ssd_pkg::WAY_W-1:0]       way_q;
  logic [ssd_pkg::ADDR_W-1:0]      addr_q;
  logic                            hit_q;

  logic [ssd_pkg::SET_W-1:0]       clr_idx;
  logic [ssd_pkg::SELECTOR_BITS-1:0] selector;

  logic accept;
  logic out_free;
  logic exec_go;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign exec_go   = (state == ST_EXEC) && out_free;

  // Victim path
  logic [ssd_pkg::WAY_W-1:0] pick;
  logic [ssd_pkg::ROW_W-1:0] aged_row;

  ssd_victim u_victim (
    .row      (rd_row),
    .pick     (pick),
    .aged_row (aged_row)
  );

  // Stride detector
  logic signed [ssd_pkg::DELTA_W-1:0] delta;
  logic [ssd_pkg::CONF_W-1:0]         conf_next;
  ssd_pkg::det_t                      det_wr;

  assign delta = $signed({1'b0, addr_q}) - $signed({1'b0, rd_det.prior_address});

  always_comb begin
    conf_next = rd_det.confidence;
    if (rd_det.prior_address != '0) begin
      if (delta == rd_det.prior_delta && delta != '0) begin
        if (rd_det.confidence != ssd_pkg::CONF_MAX) conf_next = rd_det.confidence + 2'd1;
      end else begin
        if (rd_det.confidence != '0) conf_next = rd_det.confidence - 2'd1;
      end
    end
    det_wr.prior_address = addr_q;
    det_wr.prior_delta   = delta;
    det_wr.confidence    = conf_next;
  end

  // Policy choice and insertion
  logic lead_srrip, lead_stream, srrip_mode, distant;
  logic [ssd_pkg::ROW_W-1:0]         upd_row;
  logic [ssd_pkg::SELECTOR_BITS-1:0] selector_next;

  assign lead_srrip  = int'(set_q) < ssd_pkg::LEADER_SETS;
  assign lead_stream = !lead_srrip && (int'(set_q) < 2 * ssd_pkg::LEADER_SETS);
  assign srrip_mode  = lead_srrip || (!lead_stream && selector < ssd_pkg::SEL_MID);
  assign distant     = !hit_q && !srrip_mode && conf_next >= ssd_pkg::CONF_STREAM;

  always_comb begin
    upd_row = rd_row;
    upd_row[way_q*ssd_pkg::RRPV_W +: ssd_pkg::RRPV_W] =
      distant ? ssd_pkg::RRPV_DISTANT : ssd_pkg::RRPV_NEAR;
    selector_next = selector;
    if (distant && lead_stream && selector != ssd_pkg::SEL_MAX) begin
      selector_next = selector + 1'b1;
    end else if (!hit_q && !distant && lead_srrip && selector != '0) begin
      selector_next = selector - 1'b1;
    end
  end

  // Memory write port: clearing pass or write-back
  logic                      mem_we, det_we;
  logic [ssd_pkg::SET_W-1:0] wr_addr;
  logic [ssd_pkg::ROW_W-1:0] row_wdata;
  ssd_pkg::det_t             det_wdata;

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      det_we    = 1'b1;
      wr_addr   = clr_idx;
      row_wdata = {ssd_pkg::NUM_WAYS{ssd_pkg::RRPV_START}};
      det_wdata = '0;
    end else begin
      mem_we    = exec_go;
      det_we    = exec_go && (op_q == ssd_pkg::OP_UPDATE);
      wr_addr   = set_q;
      row_wdata = (op_q == ssd_pkg::OP_UPDATE) ? upd_row : aged_row;
      det_wdata = det_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) reref_mem[wr_addr] <= row_wdata;
    if (accept) rd_row <= reref_mem[req.set_index[ssd_pkg::SET_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (det_we) det_mem[wr_addr] <= det_wdata;
    if (accept) rd_det <= det_mem[req.set_index[ssd_pkg::SET_W-1:0]];
  end

  // Control, request latch and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      selector  <= ssd_pkg::SEL_MID;
      rsp.valid <= 1'b0;
    end else begin
      // Response valid: set by a finished request, dropped after its transfer
      if (exec_go) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == ssd_pkg::SET_W'(ssd_pkg::NUM_SETS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            op_q   <= req.operation;
            set_q  <= req.set_index[ssd_pkg::SET_W-1:0];
            way_q  <= req.way_index[ssd_pkg::WAY_W-1:0];
            addr_q <= req.address;
            hit_q  <= req.was_hit;
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (op_q == ssd_pkg::OP_UPDATE) begin
              rsp.victim_way       <= '0;
              rsp.inserted_distant <= distant;
              rsp.policy_srrip     <= srrip_mode;
              selector             <= selector_next;
            end else begin
              rsp.victim_way       <= 4'(pick);
              rsp.inserted_distant <= 1'b0;
              rsp.policy_srrip     <= 1'b0;
            end
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

endmodule

// ----- sv/ssd_checker.sv -----
// Port-level checks for the replacement block, bound to the top level.
module ssd_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [3:0] victim_way,
  input logic       inserted_distant,
  input logic       policy_srrip
);

  // A response waiting on the receiver keeps its content
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(victim_way)
      && $stable(inserted_distant) && $stable(policy_srrip))
    else $error("stalled response changed");

  // One request at a time: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // Every request is followed by a response in the register
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##2 rsp_valid)
    else $error("response missing after request");

  // Distant insertion happens only under streaming, never with a victim way
  a_distant_stream: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && inserted_distant |-> !policy_srrip && victim_way == 4'd0)
    else $error("distant insertion under SRRIP policy");

endmodule

bind srrip_stream_duel_replacement ssd_checker u_ssd_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .victim_way       (rsp.victim_way),
  .inserted_distant (rsp.inserted_distant),
  .policy_srrip     (rsp.policy_srrip)
);
